>>> src/amo_pkg.sv
// ----------------------------------------------------------------------------
// amo_pkg
// Shared types and constants of the atomic memory operation unit.
// ----------------------------------------------------------------------------
package amo_pkg;

	// Default depth of the word store.
	localparam int WORDS_DEF = 256;

	localparam int DATA_W = 64;
	localparam int OP_W   = 4;
	localparam int IDX_W  = 8;
	localparam int BIT_W  = 6;

	// Request packing in s_tdata, lowest bit first.
	localparam int OP_LSB   = 0;
	localparam int SIZE_LSB = OP_LSB + OP_W;
	localparam int IDX_LSB  = SIZE_LSB + 1;
	localparam int OPA_LSB  = IDX_LSB + IDX_W;
	localparam int OPB_LSB  = OPA_LSB + DATA_W;
	localparam int BIT_LSB  = OPB_LSB + DATA_W;
	localparam int IN_BITS  = BIT_LSB + BIT_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

	// Result packing in m_tdata, lowest bit first.
	localparam int CAS_POS  = DATA_W;
	localparam int BWS_POS  = DATA_W + 1;
	localparam int OUT_BITS = DATA_W + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 4'd0,
		OP_STORE = 4'd1,
		OP_CAS   = 4'd2,
		OP_ADD   = 4'd3,
		OP_INC   = 4'd4,
		OP_DEC   = 4'd5,
		OP_OR    = 4'd6,
		OP_AND   = 4'd7,
		OP_XCHG  = 4'd8,
		OP_TSET  = 4'd9,
		OP_TCLR  = 4'd10
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_en;   // write zero at the clear counter address
		logic rd_en;    // capture request and read the addressed word
		logic mod_en;   // modify, write back and load the result register
	} amo_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last; // clear counter is at the last word
	} amo_sts_t;

endpackage

>>> src/amo_ctrl.sv
// ----------------------------------------------------------------------------
// amo_ctrl
// Controller: clearing pass, request acceptance and result handshake.
// ----------------------------------------------------------------------------
module amo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output amo_pkg::amo_cmd_t  cmd,
	input  amo_pkg::amo_sts_t  sts
);
	import amo_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_MODIFY = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_vld_q;
	logic   out_free;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

	always_comb begin
		state_d    = state_q;
		cmd.clr_en = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.mod_en = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				// The read-modify-write completes only when the result register can take it.
				if (out_free) begin
					cmd.mod_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mod_en) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("request accepted during clearing pass");

	a_accept_to_modify: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MODIFY))
		else $error("accepted request did not reach modify");

	a_modify_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_en |-> (!out_vld_q || m_tready))
		else $error("result register overwritten");

	a_modify_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_en |=> m_tvalid)
		else $error("modify did not present a result");

endmodule

>>> src/amo_dpath.sv
// ----------------------------------------------------------------------------
// amo_dpath
// Datapath: word store, request registers, modify unit and result register.
// ----------------------------------------------------------------------------
module amo_dpath #(
	parameter int WORDS = amo_pkg::WORDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [amo_pkg::IN_W-1:0]  s_tdata,
	output logic [amo_pkg::OUT_W-1:0] m_tdata,
	input  amo_pkg::amo_cmd_t         cmd,
	output amo_pkg::amo_sts_t         sts
);
	import amo_pkg::*;

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [DATA_W-1:0] mem [WORDS];

	logic [AW-1:0]     clr_cnt_q;
	op_t               op_q;
	logic              size_q;
	logic              idx_ok_q;
	logic [AW-1:0]     addr_q;
	logic [DATA_W-1:0] opa_q;
	logic [DATA_W-1:0] opb_q;
	logic [BIT_W-1:0]  bit_q;
	logic [DATA_W-1:0] rd_q;
	logic [OUT_BITS-1:0] res_q;

	logic [IDX_W-1:0]  in_idx;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] m;
	logic [DATA_W-1:0] old;
	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] b;
	logic [BIT_W-1:0]  bitp;
	logic [DATA_W-1:0] bmask;
	logic [DATA_W-1:0] addend;
	logic [DATA_W-1:0] sum;
	logic [DATA_W-1:0] nv;
	logic [DATA_W-1:0] rv;
	logic              wr;
	logic              cas;
	logic              bws;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;

	assign in_idx       = s_tdata[IDX_LSB +: IDX_W];
	assign rd_addr      = AW'(in_idx);
	assign sts.clr_last = (clr_cnt_q == AW'(WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en && !sts.clr_last) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			op_q     <= op_t'(s_tdata[OP_LSB +: OP_W]);
			size_q   <= s_tdata[SIZE_LSB];
			idx_ok_q <= (32'(in_idx) < WORDS);
			addr_q   <= rd_addr;
			opa_q    <= s_tdata[OPA_LSB +: DATA_W];
			opb_q    <= s_tdata[OPB_LSB +: DATA_W];
			bit_q    <= s_tdata[BIT_LSB +: BIT_W];
		end
	end

	always_comb begin
		m      = size_q ? '1 : {{(DATA_W/2){1'b0}}, {(DATA_W/2){1'b1}}};
		old    = rd_q & m;
		a      = opa_q & m;
		b      = opb_q & m;
		bitp   = size_q ? bit_q : {1'b0, bit_q[BIT_W-2:0]};
		bmask  = DATA_W'(1) << bitp;
		case (op_q)
			OP_INC:  addend = DATA_W'(1);
			OP_DEC:  addend = '1;
			default: addend = a;
		endcase
		sum = (old + addend) & m;
		nv  = old;
		rv  = old;
		wr  = idx_ok_q;
		cas = 1'b0;
		bws = 1'b0;
		case (op_q)
			OP_LOAD:  wr = 1'b0;
			OP_STORE: nv = b;
			OP_CAS: begin
				if (old == a) begin
					nv  = b;
					cas = 1'b1;
				end else begin
					wr = 1'b0;
				end
			end
			OP_ADD:   nv = sum;
			OP_INC, OP_DEC: begin
				nv = sum;
				rv = sum;
			end
			OP_OR:    nv = old | a;
			OP_AND:   nv = old & a;
			OP_XCHG:  nv = b;
			OP_TSET: begin
				nv  = old | bmask;
				bws = |(old & bmask);
			end
			OP_TCLR: begin
				nv  = old & ~bmask;
				bws = |(old & bmask);
			end
			default: begin
				wr = 1'b0;
				rv = '0;
			end
		endcase
		// An index outside the store yields an all-zero result.
		if (!idx_ok_q) begin
			rv  = '0;
			cas = 1'b0;
			bws = 1'b0;
		end
	end

	assign we    = cmd.clr_en || (cmd.mod_en && wr);
	assign waddr = cmd.clr_en ? clr_cnt_q : addr_q;
	assign wdata = cmd.clr_en ? '0 : ((rd_q & ~m) | (nv & m));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_en) begin
			res_q <= {bws, cas, rv};
		end
	end

	assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, res_q};

endmodule

>>> src/atomic_memory_op_unit.sv
// ----------------------------------------------------------------------------
// atomic_memory_op_unit
// Word store with an atomic read-modify-write unit.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream and each one gives exactly one result on
// the m_ stream. A request names a word, an operation (load, store, cas, add,
// inc, dec, or, and, xchg, test-and-set, test-and-clear) and a 32- or 64-bit
// size; the read, modify and write back of that word happen as one step.
// Each request is handled in a read step and a modify step: the acceptance
// cycle reads the word from the single-port store, then the modify step
// modifies it, writes it back and loads the result register. No new request is
// taken until that modify step is done; m_tvalid rises once the result is loaded.
// The result register decouples the two sides: a request can be accepted
// while the previous result is still waiting. If the receiver stalls, the
// modify step waits until the result register is free, and no further
// request is accepted until then.
// After reset the store is cleared to zero by a pass that writes one word per
// cycle through all WORDS words; s_tready stays low during that pass.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit #(
	parameter int WORDS = amo_pkg::WORDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// opcode, size_sel, word_index, operand_a, operand_b, bit_index, zero pad
	input  logic [amo_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// read_value, cas_done, bit_was_set, zero pad
	output logic [amo_pkg::OUT_W-1:0] m_tdata
);
	import amo_pkg::*;

	amo_cmd_t cmd;
	amo_sts_t sts;

	amo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	amo_dpath #(
		.WORDS (WORDS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule
